FILE: hw/rtl/adc_to_pressure_quadratic_inverse_core_defines.svh
// Assertion macros for the RTL that checks its own behavior.
`ifndef ADC_TO_PRESSURE_QUADRATIC_INVERSE_CORE_DEFINES_SVH
`define ADC_TO_PRESSURE_QUADRATIC_INVERSE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define APQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define APQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define APQ_ASSERT_IMP(lbl, ante, cons)
`define APQ_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/apq_pkg.sv
package apq_pkg;

  localparam int CFG_W   = 32;
  localparam int COEF_W  = 32;
  localparam int PRS_W   = 17;
  localparam int WHOLE_W = 9;
  localparam int IDX_W   = 3;

  localparam logic [IDX_W-1:0] REG_COEF_QUAD = 3'd0;
  localparam logic [IDX_W-1:0] REG_COEF_LIN  = 3'd1;
  localparam logic [IDX_W-1:0] REG_COEF_OFS  = 3'd2;
  localparam logic [IDX_W-1:0] REG_MIN_P     = 3'd3;
  localparam logic [IDX_W-1:0] REG_MAX_P     = 3'd4;

  localparam logic signed [PRS_W-1:0]   MAX_P_RESET  = 17'sd38400;
  localparam logic signed [PRS_W-1:0]   ERR_PRESSURE = -17'sd256;
  localparam logic signed [WHOLE_W-1:0] ERR_WHOLE    = -9'sd1;

  // Converter code to sensor volts in Q3.16: code * SCALE_NUM / (DEN_PER_LSB * full scale).
  localparam longint unsigned SCALE_NUM   = 64'd317948952576;
  localparam longint unsigned DEN_PER_LSB = 64'd968100;

  localparam int VS_W    = 19;
  localparam int CQ_W    = 33;
  localparam int BB_W    = 64;
  localparam int AC_W    = 65;
  localparam int D_W     = 68;
  localparam int S_W     = 34;
  localparam int R_W     = S_W + 2;
  localparam int NUM_W   = 44;
  localparam int DIV_W   = 33;
  localparam int Q_W     = 44;
  localparam int QS_W    = 46;

  localparam int VSC_LAT  = VS_W + 1;
  localparam int DISC_LAT = 3;
  localparam int SQRT_LAT = S_W;
  localparam int DIV_LAT  = Q_W + 3;
  localparam int SEL_LAT  = 2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_ROOT = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef struct packed {
    logic valid;
    logic no_root;
    logic a_zero;
  } item_ctl_t;

endpackage

FILE: hw/rtl/adc_to_pressure_quadratic_inverse_core.sv
// Converts one pressure sensor converter code into psi by solving the
// calibration polynomial V = a*P^2 + b*P + c with the quadratic formula.
// An item enters with start high while busy is low; adc_code is taken at
// that edge. done is high for one cycle with pressure_fixed (Q9.8 psi),
// pressure_whole and status. The receiver cannot hold results off, so done
// is a single-cycle strobe. Throughput is one item per cycle while busy is
// low: the scaling divider (20 stages), the discriminant (3 stages), the
// square root (34 stages), the two root dividers (47 stages) and the root
// selection (2 stages) are fully pipelined.
// Registers are written through cfg_we, cfg_index and cfg_data; writes to an
// unknown index are dropped. Change them only while no item is in flight.
// Reset (synchronous, rst high) empties the pipeline, restores the register
// defaults and holds busy high for the cycle after rst.
`include "adc_to_pressure_quadratic_inverse_core_defines.svh"

module adc_to_pressure_quadratic_inverse_core import apq_pkg::*; #(
  parameter int ADC_BITS = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [ADC_BITS-1:0]       adc_code,
  input  logic                      cfg_we,
  input  logic [IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  output logic                      done,
  output logic signed [PRS_W-1:0]   pressure_fixed,
  output logic signed [WHOLE_W-1:0] pressure_whole,
  output logic [1:0]                status
);

  localparam int LAT = VSC_LAT + DISC_LAT + SQRT_LAT + DIV_LAT + SEL_LAT;

  logic signed [COEF_W-1:0] coef_a;
  logic signed [COEF_W-1:0] coef_b;
  logic signed [COEF_W-1:0] coef_c;
  logic signed [PRS_W-1:0]  min_p;
  logic signed [PRS_W-1:0]  max_p;

  logic                    accept;
  logic                    vs_valid;
  logic [VS_W-1:0]         vs;
  item_ctl_t               disc_ctl;
  logic [D_W-1:0]          disc_d;
  item_ctl_t               sq_ctl;
  logic [S_W-1:0]          sq_root;
  item_ctl_t               dv_ctl;
  logic signed [QS_W-1:0]  q_plus;
  logic signed [QS_W-1:0]  q_minus;

  item_ctl_t               sel_ctl;
  logic                    sel_in1;
  logic                    sel_in2;
  logic signed [PRS_W-1:0] sel_p1;
  logic signed [PRS_W-1:0] sel_p2;

  logic                    ok;
  logic signed [PRS_W-1:0] p_sel;
  logic [PRS_W:0]          p_mag;
  logic [PRS_W-8:0]        w_mag;
  logic signed [WHOLE_W-1:0] w_val;
  status_t                 st_next;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a <= '0;
      coef_b <= '0;
      coef_c <= '0;
      min_p  <= '0;
      max_p  <= MAX_P_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COEF_QUAD: coef_a <= cfg_data;
        REG_COEF_LIN:  coef_b <= cfg_data;
        REG_COEF_OFS:  coef_c <= cfg_data;
        REG_MIN_P:     min_p  <= cfg_data[PRS_W-1:0];
        REG_MAX_P:     max_p  <= cfg_data[PRS_W-1:0];
        default: ;
      endcase
    end
  end

  apq_vscale #(.ADC_BITS(ADC_BITS)) u_vscale (
    .clk(clk), .rst(rst), .in_valid(accept), .code(adc_code),
    .out_valid(vs_valid), .vs(vs)
  );

  apq_disc u_disc (
    .clk(clk), .rst(rst), .in_valid(vs_valid), .vs(vs),
    .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
    .ctl(disc_ctl), .d(disc_d)
  );

  apq_sqrt u_sqrt (
    .clk(clk), .rst(rst), .ctl_in(disc_ctl), .d(disc_d),
    .ctl_out(sq_ctl), .root(sq_root)
  );

  apq_div u_div (
    .clk(clk), .rst(rst), .ctl_in(sq_ctl), .s(sq_root),
    .coef_a(coef_a), .coef_b(coef_b),
    .ctl_out(dv_ctl), .q_plus(q_plus), .q_minus(q_minus)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_ctl <= '0;
    end else begin
      sel_ctl <= dv_ctl;
    end
  end

  always_ff @(posedge clk) begin
    sel_in1 <= (q_plus >= QS_W'(min_p)) && (q_plus <= QS_W'(max_p));
    sel_in2 <= (q_minus >= QS_W'(min_p)) && (q_minus <= QS_W'(max_p));
    sel_p1  <= q_plus[PRS_W-1:0];
    sel_p2  <= q_minus[PRS_W-1:0];
  end

  always_comb begin
    ok    = !sel_ctl.no_root && !sel_ctl.a_zero && (sel_in1 || sel_in2);
    p_sel = sel_in1 ? sel_p1 : sel_p2;
    p_mag = p_sel[PRS_W-1] ? (PRS_W+1)'(-(PRS_W+1)'(p_sel)) : (PRS_W+1)'(p_sel);
    w_mag = p_mag[PRS_W:8];
    w_val = p_sel[PRS_W-1] ? WHOLE_W'(-$signed({1'b0, w_mag})) : WHOLE_W'(w_mag);
    if (ok) begin
      st_next = ST_OK;
    end else if (sel_ctl.no_root) begin
      st_next = ST_NO_ROOT;
    end else begin
      st_next = ST_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sel_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    status         <= st_next;
    pressure_fixed <= ok ? p_sel : ERR_PRESSURE;
    pressure_whole <= ok ? w_val : ERR_WHOLE;
  end

  `APQ_ASSERT_IMP(a_done_latency, done, $past(start && !busy, LAT))
  `APQ_ASSERT_IMP(a_err_value, done && (status != ST_OK), (pressure_fixed == ERR_PRESSURE) && (pressure_whole == ERR_WHOLE))
  `APQ_ASSERT_IMP(a_ok_in_range, done && (status == ST_OK), (pressure_fixed >= min_p) && (pressure_fixed <= max_p))
  `APQ_ASSERT_NXT(a_no_root_out, sel_ctl.valid && sel_ctl.no_root, done && (status == ST_NO_ROOT))

endmodule

FILE: hw/rtl/apq_vscale.sv
module apq_vscale import apq_pkg::*; #(
  parameter int ADC_BITS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [ADC_BITS-1:0] code,
  output logic                out_valid,
  output logic [VS_W-1:0]     vs
);

  localparam int NW = ADC_BITS + 40;
  localparam logic [NW-1:0] FS    = NW'((64'd1 << ADC_BITS) - 64'd1);
  localparam logic [NW-1:0] DEN   = NW'(DEN_PER_LSB) * FS;
  localparam logic [NW-1:0] HALF  = DEN / 2;
  localparam logic [NW-1:0] SCALE = NW'(SCALE_NUM);

  logic [NW-1:0]   rem [VS_W+1];
  logic [VS_W-1:0] quo [VS_W+1];
  logic            vld [VS_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem[0] <= NW'(code) * SCALE + HALF;
    quo[0] <= '0;
  end

  for (genvar g = 0; g < VS_W; g++) begin : g_step
    localparam int BP = VS_W - 1 - g;
    localparam logic [NW-1:0] DSH = DEN << BP;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      quo[g+1] <= quo[g];
      if (rem[g] >= DSH) begin
        rem[g+1]     <= rem[g] - DSH;
        quo[g+1][BP] <= 1'b1;
      end else begin
        rem[g+1] <= rem[g];
      end
    end
  end

  assign out_valid = vld[VS_W];
  assign vs        = quo[VS_W];

endmodule

FILE: hw/rtl/apq_disc.sv
module apq_disc import apq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [VS_W-1:0]          vs,
  input  logic signed [COEF_W-1:0] coef_a,
  input  logic signed [COEF_W-1:0] coef_b,
  input  logic signed [COEF_W-1:0] coef_c,
  output item_ctl_t                ctl,
  output logic [D_W-1:0]           d
);

  logic                    v1;
  logic signed [CQ_W-1:0]  cq1;
  logic                    v2;
  logic [BB_W-1:0]         bb2;
  logic [AC_W-1:0]         ac2;
  logic                    acpos2;
  logic                    azero2;
  logic [COEF_W-1:0]       mag_a;
  logic [COEF_W-1:0]       mag_b;
  logic [CQ_W-1:0]         mag_cq;
  logic [D_W-1:0]          bbx;
  logic [D_W-1:0]          acx;

  assign mag_a  = coef_a[COEF_W-1] ? COEF_W'(-coef_a) : COEF_W'(coef_a);
  assign mag_b  = coef_b[COEF_W-1] ? COEF_W'(-coef_b) : COEF_W'(coef_b);
  assign mag_cq = cq1[CQ_W-1] ? CQ_W'(-cq1) : CQ_W'(cq1);
  assign bbx    = D_W'(bb2);
  assign acx    = D_W'({ac2, 2'b00});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      ctl <= '0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      ctl.valid <= v2;
      ctl.no_root <= acpos2 && (bbx < acx);
      ctl.a_zero  <= azero2;
    end
  end

  always_ff @(posedge clk) begin
    cq1    <= CQ_W'(coef_c) - $signed(CQ_W'({vs, 8'b0}));
    bb2    <= BB_W'(mag_b) * BB_W'(mag_b);
    ac2    <= AC_W'(mag_a) * AC_W'(mag_cq);
    acpos2 <= (coef_a != '0) && (cq1 != '0) && (coef_a[COEF_W-1] == cq1[CQ_W-1]);
    azero2 <= (coef_a == '0);
    d      <= acpos2 ? (bbx - acx) : (bbx + acx);
  end

endmodule

FILE: hw/rtl/apq_sqrt.sv
module apq_sqrt import apq_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  item_ctl_t      ctl_in,
  input  logic [D_W-1:0] d,
  output item_ctl_t      ctl_out,
  output logic [S_W-1:0] root
);

  item_ctl_t      cp [S_W+1];
  logic [D_W-1:0] dp [S_W+1];
  logic [R_W-1:0] rp [S_W+1];
  logic [S_W-1:0] qp [S_W+1];

  assign cp[0] = ctl_in;
  assign dp[0] = d;
  assign rp[0] = '0;
  assign qp[0] = '0;

  for (genvar g = 0; g < S_W; g++) begin : g_step
    localparam int K = S_W - 1 - g;
    logic [R_W-1:0] remsh;
    logic [R_W-1:0] trial;

    assign remsh = {rp[g][R_W-3:0], dp[g][2*K+1 -: 2]};
    assign trial = {qp[g], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        cp[g+1] <= '0;
      end else begin
        cp[g+1] <= cp[g];
      end
    end

    always_ff @(posedge clk) begin
      dp[g+1] <= dp[g];
      if (remsh >= trial) begin
        rp[g+1] <= remsh - trial;
        qp[g+1] <= {qp[g][S_W-2:0], 1'b1};
      end else begin
        rp[g+1] <= remsh;
        qp[g+1] <= {qp[g][S_W-2:0], 1'b0};
      end
    end
  end

  assign ctl_out = cp[S_W];
  assign root    = qp[S_W];

endmodule

FILE: hw/rtl/apq_div.sv
module apq_div import apq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  item_ctl_t                ctl_in,
  input  logic [S_W-1:0]           s,
  input  logic signed [COEF_W-1:0] coef_a,
  input  logic signed [COEF_W-1:0] coef_b,
  output item_ctl_t                ctl_out,
  output logic signed [QS_W-1:0]   q_plus,
  output logic signed [QS_W-1:0]   q_minus
);

  localparam int T_W = S_W + 2;

  logic signed [T_W-1:0]   s_x;
  logic signed [T_W-1:0]   b_x;
  logic signed [T_W-1:0]   t_plus;
  logic signed [T_W-1:0]   t_minus;
  logic [COEF_W-1:0]       mag_a;
  logic [DIV_W-1:0]        dmag;
  item_ctl_t               ctl_a;
  item_ctl_t               ctl_b;
  logic signed [NUM_W-1:0] na [2];
  item_ctl_t               cp [Q_W+1];
  logic [NUM_W-1:0]        np [2][Q_W+1];
  logic [DIV_W-1:0]        rp [2][Q_W+1];
  logic [Q_W-1:0]          qp [2][Q_W+1];
  logic                    sp [2][Q_W+1];
  logic signed [QS_W-1:0]  qs [2];

  assign s_x     = $signed(T_W'(s));
  assign b_x     = T_W'(coef_b);
  assign t_plus  = s_x - b_x;
  assign t_minus = -b_x - s_x;
  assign mag_a   = coef_a[COEF_W-1] ? COEF_W'(-coef_a) : COEF_W'(coef_a);
  assign dmag    = {mag_a, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
      ctl_b <= '0;
    end else begin
      ctl_a <= ctl_in;
      ctl_b <= ctl_a;
    end
  end

  always_ff @(posedge clk) begin
    na[0] <= NUM_W'({t_plus, 8'b0});
    na[1] <= NUM_W'({t_minus, 8'b0});
  end

  assign cp[0] = ctl_b;

  for (genvar g = 0; g < Q_W; g++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) begin
        cp[g+1] <= '0;
      end else begin
        cp[g+1] <= cp[g];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    always_ff @(posedge clk) begin
      np[l][0] <= na[l][NUM_W-1] ? NUM_W'(-na[l]) : NUM_W'(na[l]);
      sp[l][0] <= na[l][NUM_W-1] ^ coef_a[COEF_W-1];
    end

    assign rp[l][0] = '0;
    assign qp[l][0] = '0;

    for (genvar g = 0; g < Q_W; g++) begin : g_step
      localparam int K = Q_W - 1 - g;
      logic [DIV_W:0] remsh;

      assign remsh = {rp[l][g], np[l][g][K]};

      always_ff @(posedge clk) begin
        np[l][g+1] <= np[l][g];
        sp[l][g+1] <= sp[l][g];
        if (remsh >= {1'b0, dmag}) begin
          rp[l][g+1] <= DIV_W'(remsh - {1'b0, dmag});
          qp[l][g+1] <= {qp[l][g][Q_W-2:0], 1'b1};
        end else begin
          rp[l][g+1] <= DIV_W'(remsh);
          qp[l][g+1] <= {qp[l][g][Q_W-2:0], 1'b0};
        end
      end
    end

    // Floor rounding: a negative quotient with a remainder moves one further down.
    always_ff @(posedge clk) begin
      if (sp[l][Q_W]) begin
        qs[l] <= -($signed(QS_W'(qp[l][Q_W])) + $signed(QS_W'(rp[l][Q_W] != '0)));
      end else begin
        qs[l] <= $signed(QS_W'(qp[l][Q_W]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= cp[Q_W];
    end
  end

  assign q_plus  = qs[0];
  assign q_minus = qs[1];

endmodule

FILE: tb/sv/tb_adc_to_pressure_quadratic_inverse_core.sv
module tb_adc_to_pressure_quadratic_inverse_core;
  import apq_pkg::*;

  class pressure_scoreboard;
    longint coef_a = 0;
    longint coef_b = 0;
    longint coef_c = 0;
    longint min_p = 0;
    longint max_p = 38400;
    logic [PRS_W-1:0] exp_fixed[$];
    logic [WHOLE_W-1:0] exp_whole[$];
    status_t exp_status[$];
    int errors = 0;
    int results = 0;
    int ok_count = 0;
    int no_root_count = 0;
    int range_count = 0;

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_COEF_QUAD: coef_a = longint'($signed(data));
        REG_COEF_LIN: coef_b = longint'($signed(data));
        REG_COEF_OFS: coef_c = longint'($signed(data));
        REG_MIN_P: min_p = longint'($signed(data[PRS_W-1:0]));
        REG_MAX_P: max_p = longint'($signed(data[PRS_W-1:0]));
        default: ;
      endcase
    endfunction

    function logic signed [127:0] floor_quot(logic signed [127:0] n, logic signed [127:0] d);
      logic signed [127:0] q;
      q = n / d;
      if ((n % d != 0) && ((n < 0) != (d < 0))) q = q - 1;
      return q;
    endfunction

    function void note_input(logic [9:0] code);
      longint unsigned num, den;
      logic signed [127:0] a, b, cq, disc, s, r1, r2, p, mn, mx, w;
      logic [127:0] cand, root;
      status_t st;
      num = 64'(code) * 64'd332 * 64'd14613 * 64'd65536;
      den = 64'd100 * 64'd1023 * 64'd9681;
      a = coef_a;
      b = coef_b;
      mn = min_p;
      mx = max_p;
      cq = coef_c - $signed({1'b0, 64'((num + den / 2) / den)}) * 256;
      disc = b * b - 4 * a * cq;
      st = ST_RANGE;
      p = -256;
      if (disc < 0) begin
        st = ST_NO_ROOT;
      end else if (a != 0) begin
        root = 0;
        for (int i = 40; i >= 0; i--) begin
          cand = root | (128'd1 << i);
          if (cand * cand <= disc) root = cand;
        end
        s = $signed(root);
        r1 = floor_quot((s - b) * 256, 2 * a);
        r2 = floor_quot((-b - s) * 256, 2 * a);
        if (r1 >= mn && r1 <= mx) begin
          p = r1;
          st = ST_OK;
        end else if (r2 >= mn && r2 <= mx) begin
          p = r2;
          st = ST_OK;
        end
      end
      if (st == ST_OK) begin
        w = (p >= 0) ? (p >>> 8) : -((-p) >>> 8);
        exp_whole.push_back(w[WHOLE_W-1:0]);
      end else begin
        exp_whole.push_back(ERR_WHOLE);
        p = -256;
      end
      exp_fixed.push_back(p[PRS_W-1:0]);
      exp_status.push_back(st);
    endfunction

    function void check_result(logic [PRS_W-1:0] pf, logic [WHOLE_W-1:0] pw, logic [1:0] st);
      if (exp_status.size() == 0) begin
        $display("%0t: result with none expected: %h %h %0d", $realtime, pf, pw, st);
        errors++;
        return;
      end
      results++;
      if (exp_status[0] == ST_OK) ok_count++;
      else if (exp_status[0] == ST_NO_ROOT) no_root_count++;
      else range_count++;
      if (pf !== exp_fixed[0]) begin
        $display("%0t: pressure_fixed expected %h actual %h", $realtime, exp_fixed[0], pf);
        errors++;
      end
      if (pw !== exp_whole[0]) begin
        $display("%0t: pressure_whole expected %h actual %h", $realtime, exp_whole[0], pw);
        errors++;
      end
      if (st !== exp_status[0]) begin
        $display("%0t: status expected %0d actual %0d", $realtime, exp_status[0], st);
        errors++;
      end
      void'(exp_fixed.pop_front());
      void'(exp_whole.pop_front());
      void'(exp_status.pop_front());
    endfunction

    function int pending();
      return exp_status.size();
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [9:0] adc_code = 0;
  logic cfg_we = 0;
  logic [IDX_W-1:0] cfg_index = 0;
  logic [CFG_W-1:0] cfg_data = 0;
  logic busy, done;
  logic signed [PRS_W-1:0] pressure_fixed;
  logic signed [WHOLE_W-1:0] pressure_whole;
  logic [1:0] status;
  int items = 0;
  int phases = 0;
  bit steady = 0;

  pressure_scoreboard sb = new();

  adc_to_pressure_quadratic_inverse_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .adc_code(adc_code),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
    .pressure_fixed(pressure_fixed), .pressure_whole(pressure_whole), .status(status)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_input(adc_code);
      if (done) sb.check_result(pressure_fixed, pressure_whole, status);
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic drain();
    start <= 0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic send_code(logic [9:0] code);
    int gap, pick;
    start <= 1;
    adc_code <= code;
    do @(posedge clk); while (busy);
    items++;
    pick = $urandom_range(0, 19);
    gap = (steady || pick < 12) ? 0 : (pick < 18 ? $urandom_range(1, 3) : $urandom_range(10, 40));
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_config(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                             logic [31:0] mn, logic [31:0] mx);
    drain();
    start <= 0;
    write_reg(REG_COEF_QUAD, a);
    write_reg(REG_COEF_LIN, b);
    write_reg(REG_COEF_OFS, c);
    write_reg(REG_MIN_P, mn);
    write_reg(REG_MAX_P, mx);
    write_reg(3'd5 + 3'($urandom_range(0, 2)), $urandom);
    cfg_we <= 0;
    phases++;
  endtask

  task automatic random_codes(int n);
    int kind;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind == 0) send_code($urandom_range(0, 1) ? 10'd0 : 10'd1023);
      else send_code(10'($urandom));
    end
    steady = 0;
  endtask

  initial begin
    logic [31:0] ra, rb, rc;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (int i = 0; i < 4; i++) send_code(10'($urandom));
    drain();
    load_config(32'sd1678, 32'sd503316, 32'sd8388608, -32'sd65536, 32'sd65535);
    send_code(10'd0);
    send_code(10'd1023);
    send_code(10'd1);
    send_code(10'd512);
    send_code(10'h155);
    send_code(10'h2aa);
    for (int i = 0; i < 10; i++) send_code(10'd1 << i);
    random_codes(150);
    load_config(32'sd1678, 32'sd503316, 32'sd8388608, 32'sd2560, 32'sd1280);
    random_codes(40);
    load_config(32'sd0, 32'sd503316, 32'sd8388608, 32'sd0, 32'sd38400);
    random_codes(40);
    load_config(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, -32'sd65536, 32'sd65535);
    random_codes(40);
    load_config(32'sh80000000, 32'sh7fffffff, 32'sh80000000, -32'sd65536, 32'sd65535);
    random_codes(40);
    load_config(-32'sd1678, 32'sd8388608, 32'sd4194304, 32'sd0, 32'sd38400);
    random_codes(80);
    load_config(32'sd167772, -32'sd16777216, 32'sd83886080, -32'sd65536, 32'sd65535);
    random_codes(80);
    for (int ph = 0; ph < 9; ph++) begin
      ra = 32'($signed(32'($urandom_range(0, 4000))) - 2000);
      rb = 32'($signed(32'($urandom_range(0, 2000000))) - 1000000);
      rc = 32'($signed(32'($urandom_range(0, 200000000))) - 50000000);
      if (ph % 3 == 2) begin
        ra = $urandom;
        rb = $urandom;
        rc = $urandom;
      end
      load_config(ra, rb, rc, $urandom_range(0, 3) == 0 ? 32'($urandom) : -32'sd65536,
                  $urandom_range(0, 3) == 0 ? 32'($urandom) : 32'sd65535);
      random_codes(110);
    end
    start <= 0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (120) @(posedge clk);
    $display("Run covered %0d items over %0d register settings.", items, phases);
    $display("Results: %0d ok, %0d no root, %0d out of range.",
             sb.ok_count, sb.no_root_count, sb.range_count);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/apq_pkg.sv
hw/rtl/apq_vscale.sv
hw/rtl/apq_disc.sv
hw/rtl/apq_sqrt.sv
hw/rtl/apq_div.sv
hw/rtl/adc_to_pressure_quadratic_inverse_core.sv
tb/sv/tb_adc_to_pressure_quadratic_inverse_core.sv
